>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a synchronous reset that masks it.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication whose consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/pfrb_pkg.sv
// ----------------------------------------------------------------------------
// pfrb_pkg
// Shared codes and controller/datapath interface types of the PCM frame ring.
// ----------------------------------------------------------------------------
package pfrb_pkg;

  localparam int unsigned CAP_W = 13;
  localparam int unsigned GEN_W = 32;
  localparam int unsigned CNT_W = 64;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INV_ARG   = 3'd1;
  localparam logic [2:0] ST_STALE     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_INV_STATE = 3'd4;
  localparam logic [2:0] ST_UNDERFLOW = 3'd5;

  localparam logic [3:0] SEL_FILL  = 4'd0;
  localparam logic [3:0] SEL_FREE  = 4'd1;
  localparam logic [3:0] SEL_PEAK  = 4'd2;
  localparam logic [3:0] SEL_WR    = 4'd3;
  localparam logic [3:0] SEL_RD    = 4'd4;
  localparam logic [3:0] SEL_OVF_F = 4'd5;
  localparam logic [3:0] SEL_OVF_B = 4'd6;
  localparam logic [3:0] SEL_UDF_E = 4'd7;
  localparam logic [3:0] SEL_UDF_B = 4'd8;
  localparam logic [3:0] SEL_STALE = 4'd9;
  localparam logic [3:0] SEL_INV   = 4'd10;
  localparam logic [3:0] SEL_GEN   = 4'd11;

  // Event counter slots.
  localparam int unsigned C_WR    = 0;
  localparam int unsigned C_RD    = 1;
  localparam int unsigned C_OVF_F = 2;
  localparam int unsigned C_OVF_B = 3;
  localparam int unsigned C_UDF_E = 4;
  localparam int unsigned C_UDF_B = 5;
  localparam int unsigned C_STALE = 6;
  localparam int unsigned C_INV   = 7;
  localparam int unsigned N_CNT   = 8;

  localparam logic CFG_CAPACITY  = 1'b0;
  localparam logic CFG_START_GEN = 1'b1;

  typedef struct packed {
    logic capture;   // latch the accepted input transaction
    logic exec;      // evaluate; emit the single result unless bytes follow
    logic rd_issue;  // read one ring byte
    logic rd_emit;   // move the fetched byte into the output register
  } pfrb_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a result
    logic burst;     // the current read delivers bytes
    logic last_byte; // the byte being emitted is the last of the read
  } pfrb_sts_t;

endpackage

>>> hw/rtl/pfrb_ctrl.sv
// ----------------------------------------------------------------------------
// pfrb_ctrl
// Sequencer of the PCM frame ring: one item at a time, reads byte by byte.
// ----------------------------------------------------------------------------
module pfrb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfrb_pkg::pfrb_sts_t sts,
  output pfrb_pkg::pfrb_cmd_t cmd
);
  import pfrb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_EXEC    = 4'b0010,
    S_RD_ADDR = 4'b0100,
    S_RD_DATA = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec = 1'b1;
          state_next = sts.burst ? S_RD_ADDR : S_IDLE;
        end
      end
      S_RD_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_next = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (sts.out_free) begin
          cmd.rd_emit = 1'b1;
          state_next = sts.last_byte ? S_IDLE : S_RD_ADDR;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

>>> hw/rtl/pfrb_dp.sv
// ----------------------------------------------------------------------------
// pfrb_dp
// Datapath of the PCM frame ring: byte store, pointers, counters and output.
// ----------------------------------------------------------------------------
module pfrb_dp #(
  parameter int unsigned RING_DEPTH = 4096,
  parameter int unsigned MAX_READ   = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic [1:0]               in_action,
  input  logic [7:0]               in_byte,
  input  logic [12:0]              in_frame_size,
  input  logic [6:0]               in_request,
  input  logic [31:0]              in_generation,
  input  logic                     in_stopped,
  input  logic [3:0]               in_select,
  input  pfrb_pkg::pfrb_cmd_t      cmd,
  output pfrb_pkg::pfrb_sts_t      sts,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [2:0]               out_status,
  output logic [7:0]               out_byte,
  output logic                     out_byte_valid,
  output logic [6:0]               out_count,
  output logic                     out_last,
  output logic [63:0]              out_stat
);
  import pfrb_pkg::*;

  localparam int unsigned IW   = $clog2(RING_DEPTH);
  localparam int unsigned FW   = $clog2(RING_DEPTH + 1);
  localparam int unsigned CW   = (FW > CAP_W) ? FW : CAP_W;
  localparam logic [6:0]  MAXR = 7'(MAX_READ);

  // Configuration. The start generation only matters at a register write,
  // where a nonzero value is loaded straight into the current generation.
  logic [CAP_W-1:0] cfg_cap;

  // Ring state.
  logic [7:0]       ring [RING_DEPTH];
  logic [7:0]       ring_q;
  logic [IW-1:0]    wr_idx, rd_idx, pend_idx;
  logic [FW-1:0]    fill, peak;
  logic [GEN_W-1:0] cur_gen;
  logic [CAP_W-1:0] frame_rem, frame_len;
  logic [2:0]       verdict;
  logic [CNT_W-1:0] cnt [N_CNT];

  // Latched item.
  logic [1:0]       act;
  logic [7:0]       dbyte;
  logic [12:0]      flen_in;
  logic [6:0]       req_in;
  logic [31:0]      gen_in;
  logic             stop_in;
  logic [3:0]       sel_in;

  // Read burst.
  logic [6:0]       take, k;
  logic [2:0]       rd_st;

  function automatic logic [IW-1:0] next_pos(input logic [IW-1:0] i,
                                             input logic [FW-1:0] c);
    logic [FW-1:0] n;
    n = FW'(i) + FW'(1);
    return (n >= c) ? '0 : IW'(n);
  endfunction

  // Effective capacity.
  logic [FW-1:0] cap;
  always_comb begin
    if (cfg_cap == '0) cap = FW'(1);
    else if (CW'(cfg_cap) > CW'(RING_DEPTH)) cap = FW'(RING_DEPTH);
    else cap = FW'(cfg_cap);
  end

  logic over_full;
  logic [FW-1:0] free_bytes;
  assign over_full  = fill > cap;
  assign free_bytes = over_full ? '0 : cap - fill;

  // Write evaluation.
  logic          first;
  logic [2:0]    new_v, v;
  logic [CAP_W-1:0] rem1, rem2, flen_cur;
  logic [IW-1:0] pend_cur;
  logic          commit;
  always_comb begin
    first = (frame_rem == '0);
    if (flen_in == '0 || CW'(flen_in) > CW'(cap)) new_v = ST_INV_ARG;
    else if (gen_in == '0 || gen_in != cur_gen) new_v = ST_STALE;
    else if (over_full || CW'(flen_in) > CW'(free_bytes)) new_v = ST_OVERFLOW;
    else new_v = ST_OK;
    v        = first ? new_v : verdict;
    rem1     = first ? flen_in : frame_rem;
    rem2     = (rem1 != '0) ? rem1 - 1'b1 : '0;
    pend_cur = (first && new_v == ST_OK) ? wr_idx : pend_idx;
    flen_cur = (first && new_v == ST_OK) ? flen_in : frame_len;
    commit   = (v == ST_OK) && (rem2 == '0);
  end

  // Read evaluation.
  logic [6:0] req_sat, take_c;
  logic [2:0] rd_status;
  logic       rd_ok, short_rd;
  always_comb begin
    req_sat = (req_in > MAXR) ? MAXR : req_in;
    short_rd = CW'(req_sat) > CW'(fill);
    take_c  = short_rd ? 7'(fill) : req_sat;
    rd_ok   = 1'b0;
    if (req_in == '0) rd_status = ST_INV_ARG;
    else if (gen_in == '0 || gen_in != cur_gen) rd_status = ST_STALE;
    else if (over_full) rd_status = ST_INV_STATE;
    else begin
      rd_ok = 1'b1;
      rd_status = short_rd ? ST_UNDERFLOW : ST_OK;
    end
  end

  logic rst_ok;
  assign rst_ok = stop_in && gen_in != '0 && gen_in != cur_gen;

  // Query selection.
  logic [63:0] q_val;
  logic        q_bad;
  always_comb begin
    q_val = '0;
    q_bad = 1'b0;
    case (sel_in)
      SEL_FILL:  q_val = 64'(fill);
      SEL_FREE:  q_val = 64'(free_bytes);
      SEL_PEAK:  q_val = 64'(peak);
      SEL_WR:    q_val = cnt[C_WR];
      SEL_RD:    q_val = cnt[C_RD];
      SEL_OVF_F: q_val = cnt[C_OVF_F];
      SEL_OVF_B: q_val = cnt[C_OVF_B];
      SEL_UDF_E: q_val = cnt[C_UDF_E];
      SEL_UDF_B: q_val = cnt[C_UDF_B];
      SEL_STALE: q_val = cnt[C_STALE];
      SEL_INV:   q_val = cnt[C_INV];
      SEL_GEN:   q_val = 64'(cur_gen);
      default:   q_bad = 1'b1;
    endcase
  end

  assign sts.out_free  = !out_valid || out_ready;
  assign sts.burst     = (act == ACT_READ) && rd_ok && (take_c != '0);
  assign sts.last_byte = (k + 7'd1 == take);

  // Store.
  always_ff @(posedge clk) begin
    if (cmd.exec && act == ACT_WRITE && v == ST_OK) ring[pend_cur] <= dbyte;
    if (cmd.rd_issue) ring_q <= ring[rd_idx];
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act     <= in_action;
      dbyte   <= in_byte;
      flen_in <= in_frame_size;
      req_in  <= in_request;
      gen_in  <= in_generation;
      stop_in <= in_stopped;
      sel_in  <= in_select;
    end
  end

  // Control state, pointers and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cap   <= CAP_W'(4096);
      cur_gen   <= 32'd1;
      wr_idx    <= '0;
      rd_idx    <= '0;
      pend_idx  <= '0;
      fill      <= '0;
      peak      <= '0;
      frame_rem <= '0;
      frame_len <= '0;
      verdict   <= ST_OK;
      take      <= '0;
      k         <= '0;
      rd_st     <= ST_OK;
      for (int i = 0; i < N_CNT; i++) cnt[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY: cfg_cap <= cfg_data[CAP_W-1:0];
          CFG_START_GEN: begin
            if (cfg_data != '0) cur_gen <= cfg_data;
          end
          default: ;
        endcase
      end
      if (cmd.exec) begin
        case (act)
          ACT_WRITE: begin
            if (first) begin
              verdict <= new_v;
              case (new_v)
                ST_INV_ARG: cnt[C_INV] <= cnt[C_INV] + 64'd1;
                ST_STALE:   cnt[C_STALE] <= cnt[C_STALE] + 64'd1;
                ST_OVERFLOW: begin
                  cnt[C_OVF_F] <= cnt[C_OVF_F] + 64'd1;
                  cnt[C_OVF_B] <= cnt[C_OVF_B] + 64'(flen_in);
                end
                default: ;
              endcase
            end
            frame_rem <= rem2;
            frame_len <= flen_cur;
            if (v == ST_OK) pend_idx <= next_pos(pend_cur, cap);
            if (commit) begin
              wr_idx <= next_pos(pend_cur, cap);
              fill   <= fill + FW'(flen_cur);
              cnt[C_WR] <= cnt[C_WR] + 64'(flen_cur);
              if (fill + FW'(flen_cur) > peak) peak <= fill + FW'(flen_cur);
            end
          end
          ACT_READ: begin
            if (rd_status == ST_INV_ARG || rd_status == ST_INV_STATE)
              cnt[C_INV] <= cnt[C_INV] + 64'd1;
            else if (rd_status == ST_STALE) cnt[C_STALE] <= cnt[C_STALE] + 64'd1;
            if (rd_ok) begin
              if (short_rd) begin
                cnt[C_UDF_E] <= cnt[C_UDF_E] + 64'd1;
                cnt[C_UDF_B] <= cnt[C_UDF_B] + 64'(req_sat - take_c);
              end
              fill      <= fill - FW'(take_c);
              cnt[C_RD] <= cnt[C_RD] + 64'(take_c);
            end
            take  <= take_c;
            rd_st <= rd_status;
            k     <= '0;
          end
          ACT_RESET: begin
            if (rst_ok) begin
              wr_idx    <= '0;
              rd_idx    <= '0;
              pend_idx  <= '0;
              fill      <= '0;
              peak      <= '0;
              frame_rem <= '0;
              frame_len <= '0;
              verdict   <= ST_OK;
              cur_gen   <= gen_in;
            end
          end
          default: ;
        endcase
      end
      if (cmd.rd_issue) rd_idx <= next_pos(rd_idx, cap);
      if (cmd.rd_emit) k <= k + 7'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if ((cmd.exec && !sts.burst) || cmd.rd_emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && !sts.burst) begin
      out_byte       <= '0;
      out_byte_valid <= 1'b0;
      out_count      <= '0;
      out_last       <= 1'b1;
      out_stat       <= '0;
      case (act)
        ACT_WRITE: out_status <= v;
        ACT_READ:  out_status <= rd_status;
        ACT_RESET: begin
          if (!stop_in || gen_in == '0) out_status <= ST_INV_ARG;
          else if (gen_in == cur_gen) out_status <= ST_INV_STATE;
          else out_status <= ST_OK;
        end
        default: begin
          out_status <= q_bad ? ST_INV_ARG : ST_OK;
          out_stat   <= q_val;
        end
      endcase
    end else if (cmd.rd_emit) begin
      out_status     <= rd_st;
      out_byte       <= ring_q;
      out_byte_valid <= 1'b1;
      out_count      <= take;
      out_last       <= sts.last_byte;
      out_stat       <= '0;
    end
  end
endmodule

>>> hw/rtl/pcm_frame_ring_buffer.sv
// ----------------------------------------------------------------------------
// pcm_frame_ring_buffer
// Byte ring for PCM frames with all-or-nothing frame writes and statistics.
// ----------------------------------------------------------------------------
// A write, reset or query result is registered from the latched item once
// the output register is free; a read fetches each byte and then emits it,
// in a fetch-then-emit loop on the single store port, and waits whenever
// the output register is full. The block takes a new item only after the
// last result is loaded.
// Reset (synchronous, rst high) clears pointers, fill, peak and counters and
// loads the generation with 1; the byte store itself is not cleared.
module pcm_frame_ring_buffer #(
  parameter int unsigned RING_DEPTH = 4096,
  parameter int unsigned MAX_READ   = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration writes: index 0 ring capacity, index 1 start generation.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // Input transactions.
  input  logic        s_tvalid,
  output logic        s_tready,
  // data_byte[7:0], frame_size[20:8], request_bytes[27:21],
  // generation[59:28], halted[60], stat_select[64:61], zero pad.
  input  logic [71:0] s_tdata,
  input  logic [1:0]  s_tuser,   // action
  // Result transactions.
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], data_byte_out[10:3], byte_count[17:11], stat_value[81:18],
  // zero pad.
  output logic [87:0] m_tdata,
  output logic        m_tuser,   // byte_valid
  output logic        m_tlast    // last
);
  import pfrb_pkg::*;

  pfrb_cmd_t   cmd;
  pfrb_sts_t   sts;
  logic [2:0]  o_status;
  logic [7:0]  o_byte;
  logic [6:0]  o_count;
  logic [63:0] o_stat;

  // The controller sequences one transaction at a time; the datapath owns all
  // storage, including the output register that decouples the result side.
  pfrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfrb_dp #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_READ   (MAX_READ)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_action      (s_tuser),
    .in_byte        (s_tdata[7:0]),
    .in_frame_size  (s_tdata[20:8]),
    .in_request     (s_tdata[27:21]),
    .in_generation  (s_tdata[59:28]),
    .in_stopped     (s_tdata[60]),
    .in_select      (s_tdata[64:61]),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .out_status     (o_status),
    .out_byte       (o_byte),
    .out_byte_valid (m_tuser),
    .out_count      (o_count),
    .out_last       (m_tlast),
    .out_stat       (o_stat)
  );

  assign m_tdata = {6'd0, o_stat, o_count, o_byte, o_status};
endmodule

>>> hw/rtl/pfrb_chk.sv
// ----------------------------------------------------------------------------
// pfrb_chk
// Port-level checks of the PCM frame ring, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfrb_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  import pfrb_pkg::*;

  `ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped")
  `ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "result changed")
  `ASSERT_CLK(a_byte_status, clk, rst, m_tvalid && m_tuser |-> (m_tdata[2:0] == ST_OK || m_tdata[2:0] == ST_UNDERFLOW), "bad status on read byte")
  `ASSERT_CLK(a_single_last, clk, rst, m_tvalid && !m_tuser |-> m_tlast, "single result without last")
endmodule

bind pcm_frame_ring_buffer pfrb_chk u_pfrb_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PCM frame ring: drives framed writes, reads,
// generation resets and statistics queries, and checks every result against
// a cycle-free predictor of the ring.
// ----------------------------------------------------------------------------
module tb_top;
  import pfrb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 4096;
  localparam int unsigned READ_MAX   = 64;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_ITEMS = 22;

  // One input transaction, field by field.
  typedef struct {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [12:0] frame_size;
    logic [6:0]  request_bytes;
    logic [31:0] generation;
    logic        stopped;
    logic [3:0]  stat_select;
  } ring_op_t;

  // One result transaction, field by field.
  typedef struct {
    logic [2:0]  status;
    logic [7:0]  data_out;
    logic        byte_valid;
    logic [6:0]  byte_count;
    logic        last;
    logic [63:0] stat_value;
  } ring_res_t;

  // The scoreboard holds its own copy of the ring state. note_op() works out
  // the results that an accepted transaction must cause and queues them;
  // check_result() compares each result transaction with the oldest one.
  class ring_scoreboard;
    logic [12:0] cap_reg;
    logic [31:0] cur_gen;
    logic [7:0]  ring_mem [DEPTH];
    int unsigned wr_idx, rd_idx, fill, peak, frame_rem, verdict, pend_idx, frame_len;
    logic [63:0] events [N_CNT];
    ring_res_t   awaited [$];
    int unsigned errors;

    function new();
      cap_reg  = 13'd4096;
      cur_gen  = 32'd1;
      wr_idx   = 0;
      rd_idx   = 0;
      fill     = 0;
      peak     = 0;
      frame_rem = 0;
      verdict  = ST_OK;
      pend_idx = 0;
      frame_len = 0;
      errors   = 0;
      foreach (events[i]) events[i] = '0;
      foreach (ring_mem[i]) ring_mem[i] = '0;
    endfunction

    function int unsigned cap_now();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH) return DEPTH;
      return cap_reg;
    endfunction

    function int unsigned advance(int unsigned idx);
      return (idx + 1 >= cap_now()) ? 0 : idx + 1;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == CFG_CAPACITY) cap_reg = value[12:0];
      else if (value != 0) cur_gen = value;
    endfunction

    function void push(logic [2:0] st, logic [7:0] db, logic bv, logic [6:0] cnt,
                       logic lst, logic [63:0] sv);
      ring_res_t r;
      r.status = st;
      r.data_out = db;
      r.byte_valid = bv;
      r.byte_count = cnt;
      r.last = lst;
      r.stat_value = sv;
      awaited.push_back(r);
    endfunction

    function void write_byte(ring_op_t op);
      int unsigned cap;
      cap = cap_now();
      // The verdict of a whole frame is taken on its first byte.
      if (frame_rem == 0) begin
        if (op.frame_size == 0 || op.frame_size > cap) begin
          verdict = ST_INV_ARG;
          events[C_INV]++;
        end else if (op.generation == 0 || op.generation != cur_gen) begin
          verdict = ST_STALE;
          events[C_STALE]++;
        end else if (fill > cap || op.frame_size > cap - fill) begin
          verdict = ST_OVERFLOW;
          events[C_OVF_F]++;
          events[C_OVF_B] += op.frame_size;
        end else begin
          verdict = ST_OK;
          pend_idx = wr_idx;
          frame_len = op.frame_size;
        end
        frame_rem = op.frame_size;
      end
      if (verdict == ST_OK) begin
        ring_mem[pend_idx] = op.data_byte;
        pend_idx = advance(pend_idx);
      end
      if (frame_rem > 0) frame_rem--;
      // An accepted frame becomes visible only at its last byte.
      if (verdict == ST_OK && frame_rem == 0) begin
        wr_idx = pend_idx;
        fill += frame_len;
        events[C_WR] += frame_len;
        if (fill > peak) peak = fill;
      end
      push(verdict[2:0], 0, 0, 0, 1, 0);
    endfunction

    function void read_bytes(ring_op_t op);
      int unsigned req, take;
      logic [2:0] st;
      req = op.request_bytes;
      st = ST_OK;
      if (req == 0) begin
        events[C_INV]++;
        push(ST_INV_ARG, 0, 0, 0, 1, 0);
      end else if (op.generation == 0 || op.generation != cur_gen) begin
        events[C_STALE]++;
        push(ST_STALE, 0, 0, 0, 1, 0);
      end else if (fill > cap_now()) begin
        events[C_INV]++;
        push(ST_INV_STATE, 0, 0, 0, 1, 0);
      end else begin
        if (req > READ_MAX) req = READ_MAX;
        take = req;
        if (take > fill) begin
          take = fill;
          st = ST_UNDERFLOW;
          events[C_UDF_E]++;
          events[C_UDF_B] += req - take;
        end
        if (take == 0) push(st, 0, 0, 0, 1, 0);
        for (int unsigned k = 0; k < take; k++) begin
          push(st, ring_mem[rd_idx], 1, take[6:0], k + 1 == take, 0);
          rd_idx = advance(rd_idx);
        end
        fill -= take;
        events[C_RD] += take;
      end
    endfunction

    function void gen_reset(ring_op_t op);
      logic [2:0] st;
      st = ST_OK;
      if (!op.stopped || op.generation == 0) st = ST_INV_ARG;
      else if (op.generation == cur_gen) st = ST_INV_STATE;
      else begin
        wr_idx = 0;
        rd_idx = 0;
        fill = 0;
        peak = 0;
        frame_rem = 0;
        verdict = ST_OK;
        pend_idx = 0;
        frame_len = 0;
        cur_gen = op.generation;
      end
      push(st, 0, 0, 0, 1, 0);
    endfunction

    function void query(ring_op_t op);
      logic [63:0] v;
      logic [2:0] st;
      v = '0;
      st = ST_OK;
      case (op.stat_select)
        SEL_FILL:  v = fill;
        SEL_FREE:  v = (fill > cap_now()) ? 0 : cap_now() - fill;
        SEL_PEAK:  v = peak;
        SEL_WR:    v = events[C_WR];
        SEL_RD:    v = events[C_RD];
        SEL_OVF_F: v = events[C_OVF_F];
        SEL_OVF_B: v = events[C_OVF_B];
        SEL_UDF_E: v = events[C_UDF_E];
        SEL_UDF_B: v = events[C_UDF_B];
        SEL_STALE: v = events[C_STALE];
        SEL_INV:   v = events[C_INV];
        SEL_GEN:   v = cur_gen;
        default:   st = ST_INV_ARG;
      endcase
      push(st, 0, 0, 0, 1, v);
    endfunction

    function void note_op(ring_op_t op);
      case (op.action)
        ACT_WRITE: write_byte(op);
        ACT_READ:  read_bytes(op);
        ACT_RESET: gen_reset(op);
        default:   query(op);
      endcase
    endfunction

    function void check_result(ring_res_t got);
      ring_res_t want;
      if (awaited.size() == 0) begin
        $error("result transaction with nothing awaited");
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.data_out !== want.data_out) begin
        $error("data_byte_out: expected %0d, actual %0d", want.data_out, got.data_out);
        errors++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0d, actual %0d", want.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.byte_count !== want.byte_count) begin
        $error("byte_count: expected %0d, actual %0d", want.byte_count, got.byte_count);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
      if (got.stat_value !== want.stat_value) begin
        $error("stat_value: expected %0h, actual %0h", want.stat_value, got.stat_value);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  ring_scoreboard sb = new();
  int unsigned    cycles = 0;
  int unsigned    hold_off = 0;   // receiver stall requested by the stimulus
  int unsigned    burst_left = 0;

  pcm_frame_ring_buffer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a run still going at the cycle limit fails.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL pcm_frame_ring_buffer");
      $finish;
    end
  end

  // Result monitor. Values are sampled at the rising edge, before the block
  // updates its registers for the next cycle.
  always @(posedge clk) begin
    ring_res_t r;
    if (!rst && m_tvalid && m_tready) begin
      r.status = m_tdata[2:0];
      r.data_out = m_tdata[10:3];
      r.byte_count = m_tdata[17:11];
      r.stat_value = m_tdata[81:18];
      r.byte_valid = m_tuser;
      r.last = m_tlast;
      sb.check_result(r);
    end
  end

  // Receiver back-pressure. It switches between an always-ready stretch, a
  // random pattern and a one-in-four stall, each kept for a random span. A
  // hold-off requested by the stimulus overrides the pattern while it lasts.
  initial begin
    int unsigned mode, span, tick;
    mode = 0;
    span = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(10, 60);
      end
      span--;
      if (hold_off > 0) begin
        hold_off--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= (tick % 4) != 0;
        endcase
      end
    end
  end

  // Offers one transaction and returns at the falling edge after it has been
  // accepted, with tvalid still high. The sender runs in bursts; a gap lowers
  // tvalid for a random number of cycles before the next burst starts.
  task automatic send_op(input ring_op_t op);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op.action;
    s_tdata  <= {7'd0, op.stat_select, op.stopped, op.generation, op.request_bytes,
                 op.frame_size, op.data_byte};
    do @(posedge clk); while (!s_tready);
    sb.note_op(op);
    @(negedge clk);
  endtask

  // Stops the sender and waits until every awaited result has arrived and the
  // block has settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Register write; the block is idle whenever this is called.
  task automatic cfg_write(input logic idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  function automatic ring_op_t make_op(logic [1:0] act);
    ring_op_t op;
    op.action = act;
    op.data_byte = 8'($urandom);
    op.frame_size = 13'($urandom);
    op.request_bytes = 7'($urandom);
    op.generation = $urandom;
    op.stopped = 1'($urandom);
    op.stat_select = 4'($urandom);
    return op;
  endfunction

  function automatic logic [31:0] fresh_gen();
    logic [31:0] g;
    g = $urandom | 32'd1;
    if (g == sb.cur_gen) g = g + 32'd2;
    return g;
  endfunction

  task automatic send_frame(input int unsigned len, input logic [31:0] gen);
    ring_op_t op;
    for (int unsigned i = 0; i < len; i++) begin
      op = make_op(ACT_WRITE);
      if (i == 0) begin
        op.frame_size = 13'(len);
        op.generation = gen;
      end
      send_op(op);
    end
  endtask

  task automatic send_read(input logic [6:0] req, input logic [31:0] gen);
    ring_op_t op;
    op = make_op(ACT_READ);
    op.request_bytes = req;
    op.generation = gen;
    send_op(op);
  endtask

  task automatic send_reset(input logic stopped, input logic [31:0] gen);
    ring_op_t op;
    op = make_op(ACT_RESET);
    op.stopped = stopped;
    op.generation = gen;
    send_op(op);
  endtask

  task automatic send_query(input logic [3:0] sel);
    ring_op_t op;
    op = make_op(ACT_QUERY);
    op.stat_select = sel;
    send_op(op);
  endtask

  // Clears the ring by a generation reset before a capacity change, so that
  // both indices start at zero and no read can reach a byte never written.
  task automatic new_setting(input logic [31:0] capacity);
    drain();
    send_reset(1'b1, fresh_gen());
    drain();
    cfg_write(CFG_CAPACITY, capacity);
    cfg_write(CFG_START_GEN, fresh_gen());
  endtask

  // One random transaction or sequence. Most of them are well-formed frames
  // and reads under the current generation; others are queries, resets, noise.
  task automatic random_step(output int unsigned items);
    ring_op_t op;
    int unsigned pick, len, top;
    pick = $urandom_range(0, 99);
    items = 1;
    if (pick < 48) begin
      top = (sb.cap_now() < 8) ? sb.cap_now() : 8;
      if ($urandom_range(0, 7) == 0) top = (sb.cap_now() < 70) ? sb.cap_now() : 70;
      len = $urandom_range(1, top);
      send_frame(len, sb.cur_gen);
      items = len;
    end else if (pick < 74) begin
      if ($urandom_range(0, 9) == 0) send_read(7'($urandom), $urandom);
      else send_read(7'($urandom_range(1, READ_MAX)), sb.cur_gen);
    end else if (pick < 86) begin
      send_query(4'($urandom));
    end else if (pick < 93) begin
      case ($urandom_range(0, 3))
        0: send_reset(1'($urandom), 32'd0);
        1: send_reset(1'b1, sb.cur_gen);
        default: send_reset(1'($urandom), fresh_gen());
      endcase
    end else begin
      // Noise write with every field random. A long discarded frame would
      // swallow the following writes, so it is aborted by a reset.
      send_op(make_op(ACT_WRITE));
      if (sb.frame_rem > 8) send_reset(1'b1, fresh_gen());
    end
  endtask

  initial begin
    int unsigned done, n;
    logic [31:0] caps [4];
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. A tiny ring makes the length and space checks cheap.
    cfg_write(CFG_CAPACITY, 32'd4);
    cfg_write(CFG_START_GEN, 32'd0);          // a zero start tag is not loaded
    send_query(SEL_GEN);
    drain();
    cfg_write(CFG_START_GEN, 32'hFFFF_FFFF);
    send_query(SEL_GEN);
    send_frame(0, sb.cur_gen);                // zero length: no item is sent
    send_frame(5, sb.cur_gen);                // above capacity, all bytes dropped
    send_frame(2, 32'd0);                     // stale generation
    begin
      ring_op_t op;
      op = make_op(ACT_WRITE);
      op.frame_size = 3;
      op.generation = sb.cur_gen;
      op.data_byte = 8'h00;
      send_op(op);
      op.data_byte = 8'hFF;
      send_op(op);
      op.data_byte = 8'hA5;
      send_op(op);
    end
    send_frame(2, sb.cur_gen);                // no room left: overflow
    send_read(7'd0, sb.cur_gen);              // zero request
    send_read(7'd1, sb.cur_gen + 32'd1);      // stale read
    send_read(7'd127, sb.cur_gen);            // saturated to the maximum, short
    send_read(7'd1, sb.cur_gen);              // empty ring: nothing delivered
    send_reset(1'b0, fresh_gen());            // endpoints still running
    send_reset(1'b1, 32'd0);
    send_reset(1'b1, sb.cur_gen);             // same tag again
    send_reset(1'b1, 32'h1234_5678);
    send_frame(4, sb.cur_gen);
    drain();
    // Shrinking the ring below its fill: reads and writes are refused.
    cfg_write(CFG_CAPACITY, 32'd0);
    send_read(7'd2, sb.cur_gen);
    send_frame(1, sb.cur_gen);
    send_query(SEL_FREE);
    send_query(SEL_OVF_B);

    // Random part over several ring sizes, the extremes among them.
    caps[0] = 32'd4096;
    caps[1] = 32'd1;
    caps[2] = 32'h1FFF;
    caps[3] = $urandom_range(16, 300);
    for (int p = 0; p < 4; p++) begin
      new_setting(caps[p]);
      done = 0;
      while (done < PHASE_ITEMS) begin
        // In the first phase the receiver stops for long stretches while the sender
        // keeps offering transactions, so the block backs up into its input.
        if (p == 0 && done >= 10 && hold_off == 0 && cycles < 100000) hold_off = 400;
        // In the third phase, at items 15 to 17, the sender waits for all results.
        if (p == 2 && done >= 15 && done < 18) drain();
        random_step(n);
        done += n;
      end
    end

    drain();
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASS pcm_frame_ring_buffer");
    end else begin
      $display("FAIL pcm_frame_ring_buffer");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/pfrb_pkg.sv
hw/rtl/pfrb_ctrl.sv
hw/rtl/pfrb_dp.sv
hw/rtl/pcm_frame_ring_buffer.sv
hw/rtl/pfrb_chk.sv
sim/tb_top.sv
